[rtl/dszp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dszp_pkg
// Shared types and constants of the decimal size parser.
// ----------------------------------------------------------------------------
package dszp_pkg;

  // width of the result value field
  localparam int VALUE_W = 63;
  // default accumulator width
  localparam int DEF_VALUE_BITS = 63;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // ascii constants
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CASE_MASK   = 8'hDF;
  localparam logic [7:0] CHAR_UP_K   = 8'h4B;
  localparam logic [7:0] CHAR_UP_M   = 8'h4D;
  localparam logic [7:0] CHAR_UP_G   = 8'h47;
  localparam logic [7:0] DIGIT_MAX   = 8'd9;

  // size suffix codes
  typedef enum logic [1:0] {
    SFX_NONE,
    SFX_K,
    SFX_M,
    SFX_G
  } sfx_t;

  // one input byte as held in the input stage
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       no_byte;
  } item_t;

  // result of the parse step for one byte
  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
  } res_t;

endpackage

[rtl/dszp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dszp_in_if
// Byte stream channel into the parser: valid/ready plus one ascii byte.
// ----------------------------------------------------------------------------
interface dszp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;
  logic       no_byte;

  modport source (output valid, output char_byte, output last, output no_byte,
                  input ready);
  modport sink (input valid, input char_byte, input last, input no_byte,
                output ready);
endinterface

[rtl/dszp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dszp_out_if
// Result channel of the parser: valid/ready plus value and status.
// ----------------------------------------------------------------------------
interface dszp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dszp_pkg::VALUE_W-1:0] value;
  logic [1:0]                  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

[rtl/decimal_size_parser_with_units.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_size_parser_with_units
// Parses an ascii decimal string, one byte per transaction, into an unsigned
// value with status; optional trailing K/M/G scales by 2^10/2^20/2^30.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | payload
//  in_ch    | in        | valid/ready   | char_byte[7:0], last, no_byte
//  out_ch   | out       | valid/ready   | value[62:0], status[1:0]
//  cfg      | in        | cfg_wr_en     | cfg_wr_data = units_enable
//
//  one byte per cycle sustained while out_ch is not stalled; the final byte
//  of a string lands in the input register once accepted, then the parse
//  step writes its result into the result register
//  the accumulator loop closes combinationally around acc_r, the multiply by ten as shift-adds
//  synchronous active-low reset; units_enable resets to 1
//  a stalled result holds the parse stage; the input register takes one more
// ----------------------------------------------------------------------------
module decimal_size_parser_with_units #(
  parameter int VALUE_BITS = dszp_pkg::DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  dszp_in_if.sink    in_ch,
  dszp_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic            units_r;
  logic            s1_valid_r, s1_valid_nxt;
  dszp_pkg::item_t s1_item_r;
  logic            out_valid_r, out_valid_nxt;
  dszp_pkg::res_t  out_res_r;
  dszp_pkg::res_t  res;
  logic            advance;
  logic            take;
  logic            in_take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign take        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  dszp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .item         (s1_item_r),
    .units_enable (units_r),
    .res          (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (take && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r     <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        units_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.char_byte <= in_ch.char_byte;
      s1_item_r.last      <= in_ch.last;
      s1_item_r.no_byte   <= in_ch.no_byte;
    end
    if (take && res.emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_res_r.value;
  assign out_ch.status = out_res_r.status;

endmodule

[rtl/dszp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dszp_core
// Per-byte parse step: digit accumulate with overflow precheck, size suffix
// handling, error tracking and end of string result.
// ----------------------------------------------------------------------------
module dszp_core #(
  parameter int VALUE_BITS = dszp_pkg::DEF_VALUE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  dszp_pkg::item_t item,
  input  logic            units_enable,
  output dszp_pkg::res_t  res
);

  localparam logic [VALUE_BITS-1:0] LIMIT  = '1;
  localparam logic [VALUE_BITS-1:0] CUTOFF = LIMIT / 10;
  localparam logic [3:0]            CUTLIM = 4'(LIMIT % 10);
  localparam logic [VALUE_BITS-1:0] LIM_K  = LIMIT >> 10;
  localparam logic [VALUE_BITS-1:0] LIM_M  = LIMIT >> 20;
  localparam logic [VALUE_BITS-1:0] LIM_G  = LIMIT >> 30;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]            err_r, err_nxt;
  logic                  seen_r, seen_nxt;

  logic [7:0]            up;
  logic [7:0]            d8;
  logic                  is_digit;
  logic                  ovf;
  logic [VALUE_BITS+3:0] acc_x10;
  logic [VALUE_BITS-1:0] step_acc;
  logic [1:0]            step_err;
  logic                  step_seen;
  dszp_pkg::sfx_t        sfx;
  logic [VALUE_BITS-1:0] sh_val;
  logic [VALUE_BITS-1:0] sh_lim;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] val;

  assign up       = item.char_byte & dszp_pkg::CASE_MASK;
  assign d8       = item.char_byte - dszp_pkg::CHAR_ZERO;
  assign is_digit = (d8 <= dszp_pkg::DIGIT_MAX);
  assign ovf      = (acc_r >= CUTOFF) && ((acc_r > CUTOFF) || (d8[3:0] > CUTLIM));
  // acc * 10 + d as two shifted adds
  assign acc_x10  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                    + {{VALUE_BITS{1'b0}}, d8[3:0]};

  // suffix only on the final byte with units enabled
  always_comb begin
    sfx = dszp_pkg::SFX_NONE;
    if (item.last && units_enable) begin
      if (up == dszp_pkg::CHAR_UP_G) begin
        sfx = dszp_pkg::SFX_G;
      end else if (up == dszp_pkg::CHAR_UP_M) begin
        sfx = dszp_pkg::SFX_M;
      end else if (up == dszp_pkg::CHAR_UP_K) begin
        sfx = dszp_pkg::SFX_K;
      end
    end
  end

  always_comb begin
    unique case (sfx)
      dszp_pkg::SFX_K: begin
        sh_val = acc_r << 10;
        sh_lim = LIM_K;
      end
      dszp_pkg::SFX_M: begin
        sh_val = acc_r << 20;
        sh_lim = LIM_M;
      end
      dszp_pkg::SFX_G: begin
        sh_val = acc_r << 30;
        sh_lim = LIM_G;
      end
      dszp_pkg::SFX_NONE: begin
        sh_val = acc_r;
        sh_lim = LIMIT;
      end
    endcase
  end

  // digit step, first error wins
  always_comb begin
    step_acc  = acc_r;
    step_err  = err_r;
    step_seen = seen_r;
    if (err_r == dszp_pkg::ST_OK) begin
      if (!is_digit) begin
        step_err = dszp_pkg::ST_INVALID;
      end else if (ovf) begin
        step_err = dszp_pkg::ST_OVERFLOW;
      end else begin
        step_acc  = acc_x10[VALUE_BITS-1:0];
        step_seen = 1'b1;
      end
    end
  end

  always_comb begin
    res.emit = 1'b0;
    status   = dszp_pkg::ST_OK;
    val      = acc_r;
    acc_nxt  = step_acc;
    err_nxt  = step_err;
    seen_nxt = step_seen;
    if (item.no_byte) begin
      res.emit = 1'b1;
      if (err_r != dszp_pkg::ST_OK) begin
        status = err_r;
      end else if (!seen_r) begin
        status = dszp_pkg::ST_INVALID;
      end
    end else if (sfx != dszp_pkg::SFX_NONE) begin
      res.emit = 1'b1;
      val      = sh_val;
      if (err_r != dszp_pkg::ST_OK) begin
        status = err_r;
      end else if (!seen_r) begin
        status = dszp_pkg::ST_INVALID;
      end else if (acc_r > sh_lim) begin
        status = dszp_pkg::ST_OVERFLOW;
      end
    end else if (item.last) begin
      res.emit = 1'b1;
      status   = step_err;
      val      = step_acc;
    end
    // state starts over after every result
    if (res.emit) begin
      acc_nxt  = '0;
      err_nxt  = dszp_pkg::ST_OK;
      seen_nxt = 1'b0;
    end
    res.status = status;
    res.value  = (status == dszp_pkg::ST_OK) ? dszp_pkg::VALUE_W'(val) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      err_r  <= dszp_pkg::ST_OK;
      seen_r <= 1'b0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      err_r  <= err_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule
